// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the line rasterizer walker. Every macro samples on
// the rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ELZR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rasterizer check failed");

// Consequent must hold in the cycle after the antecedent.
`define ELZR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rasterizer check failed");

`endif

// ===== src/elzr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elzr_pkg
// Widths, zone codes, queue entry type and zone reflection helpers.
// ----------------------------------------------------------------------------
package elzr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int DELTA_BITS  = COORD_BITS + 1;
  localparam int EAST_BITS   = COORD_BITS + 2;
  localparam int DEC_BITS    = COORD_BITS + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ZONE_0 = 3'd0;
  localparam logic [2:0] ZONE_1 = 3'd1;
  localparam logic [2:0] ZONE_2 = 3'd2;
  localparam logic [2:0] ZONE_3 = 3'd3;
  localparam logic [2:0] ZONE_4 = 3'd4;
  localparam logic [2:0] ZONE_5 = 3'd5;
  localparam logic [2:0] ZONE_6 = 3'd6;
  localparam logic [2:0] ZONE_7 = 3'd7;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
  } coord_pair_t;

  // One classified item waiting for the walker.
  typedef struct packed {
    logic       is_load;
    logic [2:0] zone;
    coord_t     start_x;
    coord_t     start_y;
    coord_t     start_u;
    coord_t     start_v;
    coord_t     stop_u;
    coord_t     du;
    coord_t     dv;
  } elzr_op_t;

  function automatic logic [2:0] zone_of(input logic neg_x, input logic neg_y,
                                         input logic x_major);
    logic [2:0] z;
    case ({neg_x, neg_y})
      2'b00:   z = x_major ? ZONE_0 : ZONE_1;
      2'b01:   z = x_major ? ZONE_7 : ZONE_6;
      2'b11:   z = x_major ? ZONE_4 : ZONE_5;
      default: z = x_major ? ZONE_3 : ZONE_2;
    endcase
    return z;
  endfunction

  // Map a point into zone 0 (a = u, b = v), all modulo 2^COORD_BITS.
  function automatic coord_pair_t to_zone0(input logic [2:0] z, input coord_t x,
                                           input coord_t y);
    coord_pair_t r;
    coord_t      nx;
    coord_t      ny;
    nx = '0 - x;
    ny = '0 - y;
    case (z)
      ZONE_0:  begin r.a = x;  r.b = y;  end
      ZONE_1:  begin r.a = y;  r.b = x;  end
      ZONE_2:  begin r.a = y;  r.b = nx; end
      ZONE_3:  begin r.a = nx; r.b = y;  end
      ZONE_4:  begin r.a = nx; r.b = ny; end
      ZONE_5:  begin r.a = ny; r.b = nx; end
      ZONE_6:  begin r.a = ny; r.b = x;  end
      default: begin r.a = x;  r.b = ny; end
    endcase
    return r;
  endfunction

  // Map a zone 0 point back (a = x, b = y); negations are supplied.
  function automatic coord_pair_t from_zone0(input logic [2:0] z, input coord_t u,
                                             input coord_t v, input coord_t nu,
                                             input coord_t nv);
    coord_pair_t r;
    case (z)
      ZONE_0:  begin r.a = u;  r.b = v;  end
      ZONE_1:  begin r.a = v;  r.b = u;  end
      ZONE_2:  begin r.a = nv; r.b = u;  end
      ZONE_3:  begin r.a = nu; r.b = v;  end
      ZONE_4:  begin r.a = nu; r.b = nv; end
      ZONE_5:  begin r.a = nv; r.b = nu; end
      ZONE_6:  begin r.a = v;  r.b = nu; end
      default: begin r.a = u;  r.b = nv; end
    endcase
    return r;
  endfunction

endpackage

// ===== src/eight_zone_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_zone_line_rasterizer
// Midpoint line rasterizer over all eight zones, one pixel per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready): a beat with in_action = load carries
//   both endpoints and returns the start pixel; a beat with in_action = step
//   returns the next pixel of the active line. A step with no active line
//   returns nothing. The pixel equal to the end point carries out_last_pixel
//   and closes the line; a load always replaces any line in progress.
//   Output channel (out_valid / out_ready): one pixel per result beat.
//   Throughput: one item per cycle while the result register is empty or
//   out_ready is high, set by the combinational walk update (decision add,
//   position increment and reflection back to the zone).
//   Reset: no line is active, the queue is empty and out_valid is low.
//   Stall: with out_ready low the result register holds; the two-entry queue
//   absorbs up to two more items before in_ready drops. in_ready depends
//   only on the queue fill, never combinationally on out_ready.
// ----------------------------------------------------------------------------
module eight_zone_line_rasterizer
  import elzr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   in_action,
  input  coord_t in_start_x,
  input  coord_t in_start_y,
  input  coord_t in_end_x,
  input  coord_t in_end_y,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_pixel_x,
  output coord_t out_pixel_y,
  output logic   out_last_pixel
);

  elzr_op_t front_op;
  elzr_op_t head_op;
  logic     q_full;
  logic     q_not_empty;
  logic     q_pop;
  logic     q_push;

  // Classify the beat in the same cycle it is accepted.
  elzr_front u_front (
    .action  (in_action),
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .op      (front_op)
  );

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Decouple the classifier from the walker so either side can stall.
  elzr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  // Advance the line and register the result beat.
  elzr_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (q_not_empty),
    .op         (head_op),
    .op_pop     (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (out_pixel_x),
    .pixel_y    (out_pixel_y),
    .last_pixel (out_last_pixel)
  );

endmodule

// ===== src/elzr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elzr_front
// Classify an incoming item: zone, zone 0 endpoints and deltas of a load.
// ----------------------------------------------------------------------------
module elzr_front
  import elzr_pkg::*;
(
  input  logic      action,
  input  coord_t    start_x,
  input  coord_t    start_y,
  input  coord_t    end_x,
  input  coord_t    end_y,
  output elzr_op_t  op
);

  logic [DELTA_BITS-1:0] dx;
  logic [DELTA_BITS-1:0] dy;
  logic [DELTA_BITS-1:0] ndx;
  logic [DELTA_BITS-1:0] ndy;
  coord_t                adx;
  coord_t                ady;
  logic                  x_major;
  logic [2:0]            zone;
  coord_pair_t           s_uv;
  coord_pair_t           e_uv;

  // Both orders of the subtraction in parallel; pick the magnitude by sign.
  assign dx  = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
  assign dy  = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
  assign ndx = {start_x[COORD_BITS-1], start_x} - {end_x[COORD_BITS-1], end_x};
  assign ndy = {start_y[COORD_BITS-1], start_y} - {end_y[COORD_BITS-1], end_y};
  assign adx = dx[DELTA_BITS-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ady = dy[DELTA_BITS-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

  assign x_major = adx > ady;
  assign zone    = zone_of(dx[DELTA_BITS-1], dy[DELTA_BITS-1], x_major);
  assign s_uv    = to_zone0(zone, start_x, start_y);
  assign e_uv    = to_zone0(zone, end_x, end_y);

  always_comb begin
    op.is_load = (action == ACT_LOAD);
    op.zone    = zone;
    op.start_x = start_x;
    op.start_y = start_y;
    op.start_u = s_uv.a;
    op.start_v = s_uv.b;
    op.stop_u  = e_uv.a;
    op.du      = x_major ? adx : ady;
    op.dv      = x_major ? ady : adx;
  end

endmodule

// ===== src/elzr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elzr_queue
// Two-entry queue of classified items between the front and the walker.
// ----------------------------------------------------------------------------
module elzr_queue
  import elzr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  elzr_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output elzr_op_t head_op
);

  elzr_op_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr_r;
  logic [QPTR_BITS-1:0] wptr_nxt;
  logic [QPTR_BITS-1:0] rptr_r;
  logic [QPTR_BITS-1:0] rptr_nxt;
  logic [QCNT_BITS-1:0] count_r;
  logic [QCNT_BITS-1:0] count_nxt;

  assign full      = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r + QCNT_BITS'(push) - QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_op;
    end
  end

endmodule

// ===== src/elzr_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elzr_walker
// Walk the active line one pixel per step and hold the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elzr_walker
  import elzr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     op_valid,
  input  elzr_op_t op,
  output logic     op_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output coord_t   pixel_x,
  output coord_t   pixel_y,
  output logic     last_pixel
);

  localparam logic signed [DEC_BITS-1:0] DEC_LIMIT = DEC_BITS'(2 * ((1 << COORD_BITS) - 1));

  logic                       active_r;
  logic                       active_nxt;
  logic [2:0]                 zone_r;
  logic [2:0]                 zone_nxt;
  coord_t                     u_r;
  coord_t                     u_nxt;
  coord_t                     v_r;
  coord_t                     v_nxt;
  coord_t                     stop_r;
  coord_t                     stop_nxt;
  logic signed [DEC_BITS-1:0] dec_r;
  logic signed [DEC_BITS-1:0] dec_nxt;
  logic [EAST_BITS-1:0]       east_r;
  logic [EAST_BITS-1:0]       east_nxt;
  logic signed [DEC_BITS-1:0] diag_r;
  logic signed [DEC_BITS-1:0] diag_nxt;
  logic                       ovalid_r;
  logic                       ovalid_nxt;
  coord_t                     px_r;
  coord_t                     px_nxt;
  coord_t                     py_r;
  coord_t                     py_nxt;
  logic                       last_r;
  logic                       last_nxt;

  logic                       take;
  logic                       go_diag;
  coord_t                     su;
  coord_t                     sv;
  coord_t                     snu;
  coord_t                     snv;
  logic                       s_last;
  coord_pair_t                s_xy;
  logic signed [EAST_BITS-1:0] dv_minus_du;

  assign take    = op_valid && (!ovalid_r || out_ready);
  assign op_pop  = take;
  assign go_diag = !dec_r[DEC_BITS-1];

  // Next walk position; the negation of u+1 is just ~u.
  assign su     = u_r + 1'b1;
  assign snu    = ~u_r;
  assign sv     = go_diag ? v_r + 1'b1 : v_r;
  assign snv    = go_diag ? ~v_r : '0 - v_r;
  assign s_xy   = from_zone0(zone_r, su, sv, snu, snv);
  assign s_last = (su == stop_r);

  assign dv_minus_du = signed'({2'b00, op.dv}) - signed'({2'b00, op.du});

  always_comb begin
    active_nxt = active_r;
    zone_nxt   = zone_r;
    u_nxt      = u_r;
    v_nxt      = v_r;
    stop_nxt   = stop_r;
    dec_nxt    = dec_r;
    east_nxt   = east_r;
    diag_nxt   = diag_r;
    ovalid_nxt = ovalid_r && !out_ready;
    px_nxt     = px_r;
    py_nxt     = py_r;
    last_nxt   = last_r;
    if (take) begin
      if (op.is_load) begin
        // Restart on every load, dropping any line in progress.
        zone_nxt   = op.zone;
        u_nxt      = op.start_u;
        v_nxt      = op.start_v;
        stop_nxt   = op.stop_u;
        dec_nxt    = signed'({2'b00, op.dv, 1'b0}) - signed'({3'b000, op.du});
        east_nxt   = {1'b0, op.dv, 1'b0};
        diag_nxt   = {dv_minus_du, 1'b0};
        active_nxt = (op.du != '0);
        ovalid_nxt = 1'b1;
        px_nxt     = op.start_x;
        py_nxt     = op.start_y;
        last_nxt   = (op.du == '0);
      end else if (active_r) begin
        u_nxt      = su;
        v_nxt      = sv;
        dec_nxt    = go_diag ? dec_r + diag_r : dec_r + signed'({1'b0, east_r});
        active_nxt = !s_last;
        ovalid_nxt = 1'b1;
        px_nxt     = s_xy.a;
        py_nxt     = s_xy.b;
        last_nxt   = s_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      zone_r   <= ZONE_0;
      u_r      <= '0;
      v_r      <= '0;
      stop_r   <= '0;
      dec_r    <= '0;
      east_r   <= '0;
      diag_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      zone_r   <= zone_nxt;
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      stop_r   <= stop_nxt;
      dec_r    <= dec_nxt;
      east_r   <= east_nxt;
      diag_r   <= diag_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
  end

  assign out_valid  = ovalid_r;
  assign pixel_x    = px_r;
  assign pixel_y    = py_r;
  assign last_pixel = last_r;

  `ELZR_ASSERT_NEXT(a_load_beats, take && op.is_load, ovalid_r)
  `ELZR_ASSERT_NEXT(a_step_beats, take && !op.is_load && active_r, ovalid_r)
  `ELZR_ASSERT_NEXT(a_end_stops, take && !op.is_load && active_r && s_last, !active_r)
  `ELZR_ASSERT_SAME(a_dec_range, 1'b1, (dec_r <= DEC_LIMIT) && (dec_r >= -DEC_LIMIT))

endmodule

// ===== dv/eight_zone_line_rasterizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_zone_line_rasterizer_test
// Self-checking bench for the eight-zone midpoint line rasterizer. A scoreboard
// keeps its own copy of the walker state, predicts every pixel from the
// accepted input beats and compares each output beat in order. Stimulus is a
// short directed list, followed by random lines walked to their end,
// interrupted or overrun, with random idling on both channels and one long
// output stall.
// ----------------------------------------------------------------------------
module eight_zone_line_rasterizer_test
  import elzr_pkg::*;
();

  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 400;   // long output stall, fills the queue
  localparam int STALL_LIMIT  = 2500;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 20;    // watch for stray beats after the drain, so be generous

  // One expected pixel.
  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // Scoreboard: holds the walker state and the queue of pixels still owed.
  class line_walk_scoreboard_t;
    logic                 walking;
    logic [2:0]           zone;
    coord_t               pos_u;
    coord_t               pos_v;
    coord_t               end_u;
    logic signed [14:0]   decision;
    logic [13:0]          east_inc;
    logic signed [14:0]   diag_inc;
    pixel_t               expected_pixels[$];
    int                   mismatches;

    function new();
      walking    = 1'b0;
      zone       = ZONE_0;
      pos_u      = '0;
      pos_v      = '0;
      end_u      = '0;
      decision   = '0;
      east_inc   = '0;
      diag_inc   = '0;
      mismatches = 0;
    endfunction

    // Fold a point or a delta into zone 0.
    function void fold(input logic [2:0] z, input int x, input int y,
                       output int u, output int v);
      case (z)
        ZONE_0:  begin u = x;  v = y;  end
        ZONE_1:  begin u = y;  v = x;  end
        ZONE_2:  begin u = y;  v = -x; end
        ZONE_3:  begin u = -x; v = y;  end
        ZONE_4:  begin u = -x; v = -y; end
        ZONE_5:  begin u = -y; v = -x; end
        ZONE_6:  begin u = -y; v = x;  end
        default: begin u = x;  v = -y; end
      endcase
    endfunction

    // Account for one accepted input beat; queue the pixel it yields, if any.
    function void take_item(input logic action, input coord_t sx, input coord_t sy,
                            input coord_t ex, input coord_t ey);
      int     sxi, syi, exi, eyi, dx, dy, ax, ay;
      int     du, dv, su, sv, eu, ev;
      coord_t nu, nv;
      pixel_t pix;
      if (action == ACT_LOAD) begin
        sxi = int'($signed(sx));
        syi = int'($signed(sy));
        exi = int'($signed(ex));
        eyi = int'($signed(ey));
        dx  = exi - sxi;
        dy  = eyi - syi;
        ax  = (dx < 0) ? -dx : dx;
        ay  = (dy < 0) ? -dy : dy;
        // Ties (|dx| == |dy|) go to the steep zone of each quadrant.
        if (dx >= 0 && dy >= 0) zone = (dx > dy) ? ZONE_0 : ZONE_1;
        else if (dx >= 0)       zone = (ax > ay) ? ZONE_7 : ZONE_6;
        else if (dy < 0)        zone = (ax > ay) ? ZONE_4 : ZONE_5;
        else                    zone = (ax > ay) ? ZONE_3 : ZONE_2;
        fold(zone, dx, dy, du, dv);
        fold(zone, sxi, syi, su, sv);
        fold(zone, exi, eyi, eu, ev);
        pos_u    = coord_t'(su);
        pos_v    = coord_t'(sv);
        end_u    = coord_t'(eu);
        decision = 15'(2 * dv - du);
        east_inc = 14'(2 * dv);
        diag_inc = 15'(2 * (dv - du));
        walking  = (du != 0);
        pix.x    = sx;
        pix.y    = sy;
        pix.last = !walking;
        expected_pixels.push_back(pix);
      end else if (walking) begin
        if (decision < 0) begin
          decision = decision + $signed({1'b0, east_inc});
        end else begin
          decision = decision + diag_inc;
          pos_v    = pos_v + 1'b1;
        end
        pos_u = pos_u + 1'b1;
        nu    = '0 - pos_u;
        nv    = '0 - pos_v;
        // Unfold back into the line's own zone, all modulo the coordinate width.
        case (zone)
          ZONE_0:  begin pix.x = pos_u; pix.y = pos_v; end
          ZONE_1:  begin pix.x = pos_v; pix.y = pos_u; end
          ZONE_2:  begin pix.x = nv;    pix.y = pos_u; end
          ZONE_3:  begin pix.x = nu;    pix.y = pos_v; end
          ZONE_4:  begin pix.x = nu;    pix.y = nv;    end
          ZONE_5:  begin pix.x = nv;    pix.y = nu;    end
          ZONE_6:  begin pix.x = pos_v; pix.y = nu;    end
          default: begin pix.x = pos_u; pix.y = nv;    end
        endcase
        pix.last = (pos_u == end_u);
        if (pix.last) walking = 1'b0;
        expected_pixels.push_back(pix);
      end
    endfunction

    task report(input string msg);
      if (mismatches < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one output beat against the oldest owed pixel.
    task compare_pixel(input coord_t x, input coord_t y, input logic last);
      pixel_t pix;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected pixel (%0d,%0d) last=%b",
                         $signed(x), $signed(y), last));
      end else begin
        pix = expected_pixels.pop_front();
        if (x !== pix.x)
          report($sformatf("pixel_x %0d, want %0d", $signed(x), $signed(pix.x)));
        if (y !== pix.y)
          report($sformatf("pixel_y %0d, want %0d", $signed(y), $signed(pix.y)));
        if (last !== pix.last)
          report($sformatf("last_pixel %b, want %b at (%0d,%0d)",
                           last, pix.last, $signed(pix.x), $signed(pix.y)));
      end
    endtask
  endclass

  logic   clk            = 1'b0;
  logic   rst_n          = 1'b0;
  logic   in_valid       = 1'b0;
  logic   in_ready;
  logic   in_action      = ACT_LOAD;
  coord_t in_start_x     = '0;
  coord_t in_start_y     = '0;
  coord_t in_end_x       = '0;
  coord_t in_end_y       = '0;
  logic   out_valid;
  logic   out_ready      = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_last_pixel;

  // Stimulus controls seen by the receiver process.
  logic   calm           = 1'b0;  // no idling on either side
  logic   hold_req       = 1'b0;  // ask the receiver for its long stall
  logic   hold_taken     = 1'b0;
  int     hold_left      = 0;
  int     quiet_cycles   = 0;

  line_walk_scoreboard_t sb = new();

  eight_zone_line_rasterizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random back-pressure, none while calm, and one long hold-off
  // counted here so the block fills up and drops in_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  // Sample both channels mid-cycle, where every signal is settled; a beat seen
  // here is taken at the next rising edge. Check output beats and watch for a
  // hang.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.compare_pixel(out_pixel_x, out_pixel_y, out_last_pixel);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d quiet cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one beat: idle at random first, then hold valid and payload until
  // the beat is taken. Returns on the accepting edge.
  task automatic send_item(input logic action, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= action;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    do @(negedge clk); while (!in_ready);
    sb.take_item(action, sx, sy, ex, ey);
    @(posedge clk);
  endtask

  // Advance n pixels; the endpoint fields are ignored, so fill them with noise.
  task automatic send_steps(input int n);
    repeat (n)
      send_item(ACT_STEP, coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom));
  endtask

  // Offset a coordinate, mirroring the offset when it would leave the range.
  function automatic coord_t offset_coord(input coord_t c, input int d);
    int t;
    t = int'($signed(c)) + d;
    if (t > 2047 || t < -2048) t = int'($signed(c)) - d;
    return coord_t'(t);
  endfunction

  initial begin
    int     item_count;
    int     roll;
    int     spread;
    int     span;
    int     n;
    coord_t sx, sy, ex, ey;

    item_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: step with no line, then single point, extreme diagonals
    // through every tie rule, reload while a line is active, and a short
    // horizontal line walked to its end.
    send_steps(1);
    send_item(ACT_LOAD, 12'sd0, 12'sd0, 12'sd0, 12'sd0);
    send_item(ACT_LOAD, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
    send_steps(3);
    send_item(ACT_LOAD, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047);
    send_steps(2);
    send_item(ACT_LOAD, 12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048);
    send_steps(1);
    send_item(ACT_LOAD, -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048);
    send_steps(1);
    send_item(ACT_LOAD, 12'sd5, 12'sd5, 12'sd7, 12'sd5);
    send_steps(2);
    // Reflected u crosses the top of the range and wraps in the walker.
    send_item(ACT_LOAD, -12'sd2045, 12'sd0, -12'sd2048, 12'sd1);
    send_steps(3);
    send_item(ACT_LOAD, 12'sd0, 12'sd0, -12'sd3, -12'sd1);
    send_steps(3);

    // Random: mostly whole lines, some cut short or overrun, plus noise.
    while (item_count < RANDOM_ITEMS) begin
      calm     <= (item_count >= 400 && item_count < 700);
      hold_req <= (item_count >= 1000);
      roll = $urandom_range(99);
      if (roll < 85) begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        roll = $urandom_range(99);
        if (roll < 95) begin
          spread = (roll < 80) ? 24 : 300;
          ex = offset_coord(sx, int'($urandom_range(2 * spread)) - spread);
          ey = offset_coord(sy, int'($urandom_range(2 * spread)) - spread);
        end else begin
          ex = coord_t'($urandom);
          ey = coord_t'($urandom);
        end
        span = int'($signed(ex)) - int'($signed(sx));
        n    = int'($signed(ey)) - int'($signed(sy));
        if (span < 0) span = -span;
        if (n < 0) n = -n;
        if (n > span) span = n;
        send_item(ACT_LOAD, sx, sy, ex, ey);
        n = span;
        if (n > 120) n = $urandom_range(120, 1);
        else if ($urandom_range(9) == 0) n = $urandom_range(span);
        send_steps(n);
        item_count += n + 1;
        // Overrun a finished line: the extra step yields nothing.
        if (n == span && $urandom_range(3) == 0) send_steps(1);
      end else if (roll < 92) begin
        send_steps(1);
        item_count++;
      end else begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        send_item(ACT_LOAD, sx, sy, sx, sy);
        item_count++;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed pixel, then watch for strays.
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
